/* hdl/ppt_pkg.sv */
// Shared types and constants for the position and PnL tracker.
`default_nettype none

package ppt_pkg;

  // Configuration port
  localparam int PADDR_W = 3;
  localparam logic [PADDR_W-3:0] REG_INITIAL_CASH = 1'b0;
  localparam logic [31:0] INITIAL_CASH_RESET = 32'd100000;

  // Operand pairs fed to the shared 32x32 multiplier
  typedef enum logic [2:0] {
    MS_CASH,    // qty * price
    MS_AVG_LO,  // old magnitude * avg[31:0]
    MS_AVG_HI,  // old magnitude * avg[63:32]
    MS_NEW,     // added qty * price
    MS_PNL_LO,  // closed qty * diff[31:0]
    MS_PNL_HI   // closed qty * diff[63:32]
  } mul_sel_t;

  typedef enum logic [2:0] {
    ACC_NONE,
    ACC_CASH,     // hold product as the cash move
    ACC_LOAD,     // acc = product
    ACC_ADD32,    // acc += product << 32
    ACC_ADDFRAC   // acc += product << FRAC_BITS
  } acc_op_t;

  typedef struct packed {
    logic     capture;
    logic     decode;
    logic     mul_en;
    mul_sel_t mul_sel;
    acc_op_t  acc_op;
    logic     div_init;
    logic     div_step;
    logic     commit;
  } ppt_cmd_t;

  typedef struct packed {
    logic active;
    logic adding;
    logic nmag_zero;
  } ppt_status_t;

endpackage

`default_nettype wire

/* hdl/ppt_ctrl.sv */
// Sequencer for the tracker: accepts a fill, steps the datapath, hands off the result.
`default_nettype none

module ppt_ctrl #(
  parameter int DIV_STEPS = 48
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  input  wire ppt_pkg::ppt_status_t status,
  output ppt_pkg::ppt_cmd_t         cmd
);

  localparam int CNT_W = $clog2(DIV_STEPS);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_MUL_CASH,
    S_ACC_CASH,
    S_MUL_LO,
    S_ACC_LO,
    S_MUL_HI,
    S_ACC_HI,
    S_MUL_NEW,
    S_ACC_NEW,
    S_DIV_INIT,
    S_DIV,
    S_DONE
  } state_t;

  state_t state;
  logic [CNT_W-1:0] cnt;
  logic handoff;

  assign in_stall = (state != S_IDLE);
  assign handoff  = (state == S_DONE) && (!out_valid || !out_stall);

  always_comb begin
    cmd          = '0;
    cmd.mul_sel  = ppt_pkg::MS_CASH;
    cmd.acc_op   = ppt_pkg::ACC_NONE;
    cmd.capture  = (state == S_IDLE) && in_valid;
    cmd.decode   = (state == S_DECODE);
    cmd.div_init = (state == S_DIV_INIT);
    cmd.div_step = (state == S_DIV);
    cmd.commit   = handoff;
    unique case (state)
      S_MUL_CASH: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = ppt_pkg::MS_CASH;
      end
      S_MUL_LO: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = status.adding ? ppt_pkg::MS_AVG_LO : ppt_pkg::MS_PNL_LO;
      end
      S_MUL_HI: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = status.adding ? ppt_pkg::MS_AVG_HI : ppt_pkg::MS_PNL_HI;
      end
      S_MUL_NEW: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = ppt_pkg::MS_NEW;
      end
      S_ACC_CASH: cmd.acc_op = ppt_pkg::ACC_CASH;
      S_ACC_LO:   cmd.acc_op = ppt_pkg::ACC_LOAD;
      S_ACC_HI:   cmd.acc_op = ppt_pkg::ACC_ADD32;
      S_ACC_NEW:  cmd.acc_op = ppt_pkg::ACC_ADDFRAC;
      S_IDLE, S_DECODE, S_DIV_INIT, S_DIV, S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (handoff)
        out_valid <= 1'b1;
      else if (!out_stall)
        out_valid <= 1'b0;

      unique case (state)
        S_IDLE:     if (in_valid) state <= S_DECODE;
        S_DECODE:   state <= status.active ? S_MUL_CASH : S_DONE;
        S_MUL_CASH: state <= S_ACC_CASH;
        S_ACC_CASH: state <= S_MUL_LO;
        S_MUL_LO:   state <= S_ACC_LO;
        S_ACC_LO:   state <= S_MUL_HI;
        S_MUL_HI:   state <= S_ACC_HI;
        S_ACC_HI:   state <= status.adding ? S_MUL_NEW : S_DONE;
        S_MUL_NEW:  state <= S_ACC_NEW;
        S_ACC_NEW:  state <= status.nmag_zero ? S_DONE : S_DIV_INIT;
        S_DIV_INIT: begin
          cnt   <= CNT_W'(DIV_STEPS - 1);
          state <= S_DIV;
        end
        S_DIV: begin
          if (cnt == '0)
            state <= S_DONE;
          else
            cnt <= cnt - 1'b1;
        end
        S_DONE:     if (handoff) state <= S_IDLE;
        default:    state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

/* hdl/ppt_dp.sv */
// Datapath: fill decode, shared multiplier and accumulator, restoring divider, state.
`default_nettype none

module ppt_dp #(
  parameter int PRICE_BITS = 32,
  parameter int QTY_BITS   = 20,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire ppt_pkg::ppt_cmd_t       cmd,
  output ppt_pkg::ppt_status_t         status,
  input  wire logic                    cfg_load,
  input  wire logic [31:0]             cfg_cash,
  input  wire logic                    strategy_is_buyer,
  input  wire logic                    strategy_is_seller,
  input  wire logic [QTY_BITS-1:0]     fill_quantity,
  input  wire logic [PRICE_BITS-1:0]   fill_price,
  output logic signed [31:0]           net_position,
  output logic [47:0]                  entry_price,
  output logic signed [63:0]           cash_balance,
  output logic                         pnl_valid,
  output logic signed [63:0]           realized_pnl,
  output logic                         position_overflow
);

  localparam int AVG_BITS = PRICE_BITS + FRAC_BITS;
  localparam int ACC_W    = AVG_BITS + 32;
  localparam int PM_W     = (ACC_W > 64) ? ACC_W : 64;

  // captured fill
  logic                  cap_buy, cap_sell;
  logic [QTY_BITS-1:0]   cap_qty;
  logic [PRICE_BITS-1:0] cap_price;

  // tracked state
  logic [31:0]           position;
  logic [AVG_BITS-1:0]   avg;
  logic [63:0]           cash;

  // decode
  logic [31:0]           q32, p32, mag, np_sat, nmag, closed, rest, mag_after;
  logic [32:0]           np33;
  logic                  np_ovf, adding;
  logic [AVG_BITS-1:0]   price_fx, gain, loss, diff;
  logic [31:0]           close_pos;
  logic [AVG_BITS-1:0]   close_avg;

  // decoded, registered
  logic                  d_act, d_buy, d_adding, d_ovf, d_neg;
  logic [31:0]           d_pos_new, d_mag, d_nmag, d_added, d_closed;
  logic [AVG_BITS-1:0]   d_avg_close, d_diff;

  // arithmetic
  logic [31:0]           mul_a, mul_b;
  logic [63:0]           prod, cash_prod;
  logic [ACC_W-1:0]      acc;
  logic [31:0]           rem;
  logic [AVG_BITS-1:0]   dq;
  logic [32:0]           div_t, div_sub;
  logic                  div_ge;
  logic [63:0]           avg64, diff64;

  // commit
  logic [31:0]           pos_n;
  logic [AVG_BITS-1:0]   avg_n;
  logic [63:0]           cash_n, pnl_n;
  logic [PM_W-1:0]       pm;
  logic                  pnl_valid_n;

  // ---------------- fill decode ----------------
  always_comb begin
    q32      = 32'(cap_qty);
    p32      = 32'(cap_price);
    mag      = position[31] ? (~position + 32'd1) : position;
    adding   = cap_buy ? !position[31] : (position[31] || position == 32'd0);
    np33     = cap_buy ? ({position[31], position} + {1'b0, q32})
                       : ({position[31], position} - {1'b0, q32});
    np_ovf   = np33[32] ^ np33[31];
    np_sat   = np_ovf ? (np33[32] ? 32'h8000_0000 : 32'h7fff_ffff) : np33[31:0];
    nmag     = np_sat[31] ? (~np_sat + 32'd1) : np_sat;
    closed   = (q32 < mag) ? q32 : mag;
    rest     = q32 - closed;
    mag_after = mag - closed;
    price_fx = AVG_BITS'(cap_price) << FRAC_BITS;
    gain     = cap_buy ? avg : price_fx;
    loss     = cap_buy ? price_fx : avg;
    diff     = (loss > gain) ? (loss - gain) : (gain - loss);
    if (rest != 32'd0)
      close_pos = cap_buy ? rest : (~rest + 32'd1);
    else
      close_pos = position[31] ? (~mag_after + 32'd1) : mag_after;
    if (rest != 32'd0)
      close_avg = price_fx;
    else if (mag_after == 32'd0)
      close_avg = '0;
    else
      close_avg = avg;
  end

  assign status.active    = cap_buy || cap_sell;
  assign status.adding    = d_adding;
  assign status.nmag_zero = (d_nmag == 32'd0);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cap_buy   <= strategy_is_buyer;
      cap_sell  <= strategy_is_seller;
      cap_qty   <= fill_quantity;
      cap_price <= fill_price;
    end
    if (cmd.decode) begin
      d_act       <= cap_buy || cap_sell;
      d_buy       <= cap_buy;
      d_adding    <= adding;
      d_ovf       <= np_ovf;
      d_neg       <= loss > gain;
      d_pos_new   <= adding ? np_sat : close_pos;
      d_mag       <= mag;
      d_nmag      <= nmag;
      d_added     <= nmag - mag;
      d_closed    <= closed;
      d_avg_close <= close_avg;
      d_diff      <= diff;
    end
  end

  // ---------------- multiply / accumulate ----------------
  assign avg64  = 64'(avg);
  assign diff64 = 64'(d_diff);

  always_comb begin
    unique case (cmd.mul_sel)
      ppt_pkg::MS_CASH:   begin mul_a = q32;      mul_b = p32;          end
      ppt_pkg::MS_AVG_LO: begin mul_a = d_mag;    mul_b = avg64[31:0];  end
      ppt_pkg::MS_AVG_HI: begin mul_a = d_mag;    mul_b = avg64[63:32]; end
      ppt_pkg::MS_NEW:    begin mul_a = d_added;  mul_b = p32;          end
      ppt_pkg::MS_PNL_LO: begin mul_a = d_closed; mul_b = diff64[31:0]; end
      ppt_pkg::MS_PNL_HI: begin mul_a = d_closed; mul_b = diff64[63:32]; end
      default:            begin mul_a = '0;       mul_b = '0;           end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en)
      prod <= mul_a * mul_b;
    unique case (cmd.acc_op)
      ppt_pkg::ACC_NONE:    ;
      ppt_pkg::ACC_CASH:    cash_prod <= prod;
      ppt_pkg::ACC_LOAD:    acc <= ACC_W'(prod);
      ppt_pkg::ACC_ADD32:   acc <= acc + ACC_W'({prod, 32'd0});
      ppt_pkg::ACC_ADDFRAC: acc <= acc + ACC_W'({32'd0, prod} << FRAC_BITS);
      default:              ;
    endcase
  end

  // ---------------- restoring divider, one quotient bit per cycle ----------------
  // Weighted average never exceeds the larger price, so the top 32 bits of the
  // dividend are already below the divisor and only AVG_BITS steps remain.
  assign div_t   = {rem, dq[AVG_BITS-1]};
  assign div_sub = div_t - {1'b0, d_nmag};
  assign div_ge  = div_t >= {1'b0, d_nmag};

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem <= acc[ACC_W-1:AVG_BITS];
      dq  <= acc[AVG_BITS-1:0];
    end else if (cmd.div_step) begin
      rem <= div_ge ? div_sub[31:0] : div_t[31:0];
      dq  <= {dq[AVG_BITS-2:0], div_ge};
    end
  end

  // ---------------- commit ----------------
  always_comb begin
    pos_n  = d_act ? d_pos_new : position;
    if (!d_act)
      avg_n = avg;
    else if (d_adding)
      avg_n = (d_nmag == 32'd0) ? '0 : dq;
    else
      avg_n = d_avg_close;
    if (!d_act)
      cash_n = cash;
    else
      cash_n = d_buy ? (cash - cash_prod) : (cash + cash_prod);
    pnl_valid_n = d_act && !d_adding && (d_closed != 32'd0);
    pm = PM_W'(acc);
    if (!pnl_valid_n)
      pnl_n = 64'd0;
    else if (!d_neg)
      pnl_n = (pm > PM_W'(64'h7fff_ffff_ffff_ffff)) ? 64'h7fff_ffff_ffff_ffff : pm[63:0];
    else
      pnl_n = (pm > PM_W'(64'h8000_0000_0000_0000)) ? 64'h8000_0000_0000_0000
                                                      : (64'd0 - pm[63:0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position <= '0;
      avg      <= '0;
      cash     <= 64'(ppt_pkg::INITIAL_CASH_RESET);
    end else if (cfg_load) begin
      cash <= 64'(cfg_cash);
    end else if (cmd.commit) begin
      position <= pos_n;
      avg      <= avg_n;
      cash     <= cash_n;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      net_position      <= pos_n;
      entry_price       <= 48'(avg_n);
      cash_balance      <= cash_n;
      pnl_valid         <= pnl_valid_n;
      realized_pnl      <= pnl_n;
      position_overflow <= d_act && d_adding && d_ovf;
    end
  end

endmodule

`default_nettype wire

/* hdl/position_pnl_tracker.sv */
// Top level of the average-cost position and PnL tracker.
`default_nettype none

// Channel   Handshake               Payload
// -------   ---------------------   -----------------------------------------------
// in        in_valid / in_stall     strategy_is_buyer, strategy_is_seller,
//                                   fill_quantity, fill_price
// out       out_valid / out_stall   net_position, entry_price, cash_balance,
//                                   pnl_valid, realized_pnl, position_overflow
// cfg       APB write/read          initial_cash at byte address 0
//
// One fill at a time. A fill for neither side skips the arithmetic; a closing
// fill takes the cash and PnL products, an adding fill the cash, old-cost and
// added-cost products, then the restoring divider for the new average, which
// retires one quotient bit per cycle. All products share one 32x32 multiplier.
// Reset is synchronous; it clears the position and average price and loads
// cash and initial_cash with 100000. No clearing pass is needed.
// A finished beat waits in the output register while out_stall is high; the
// next fill can be taken meanwhile and holds in its final cycle until the
// output register frees up.

module position_pnl_tracker #(
  parameter int PRICE_BITS = 32,
  parameter int QTY_BITS   = 20,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // fill beats
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic                        strategy_is_buyer,
  input  wire logic                        strategy_is_seller,
  input  wire logic [QTY_BITS-1:0]         fill_quantity,
  input  wire logic [PRICE_BITS-1:0]       fill_price,
  // result beats
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic signed [31:0]               net_position,
  output logic [47:0]                      entry_price,
  output logic signed [63:0]               cash_balance,
  output logic                             pnl_valid,
  output logic signed [63:0]               realized_pnl,
  output logic                             position_overflow,
  // configuration
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [ppt_pkg::PADDR_W-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  ppt_pkg::ppt_cmd_t    cmd;
  ppt_pkg::ppt_status_t status;

  logic [31:0] initial_cash;
  logic        cfg_hit;
  logic        cfg_load;

  // Register decode: word index sits above the byte offset.
  assign pready   = 1'b1;
  assign cfg_hit  = (paddr[ppt_pkg::PADDR_W-1:2] == ppt_pkg::REG_INITIAL_CASH);
  assign cfg_load = psel && penable && pwrite && pready && cfg_hit;
  assign prdata   = cfg_hit ? initial_cash : 32'd0;

  always_ff @(posedge clk) begin
    if (rst)
      initial_cash <= ppt_pkg::INITIAL_CASH_RESET;
    else if (cfg_load)
      initial_cash <= pwdata;
  end

  // Sequencer: one divider step per quotient bit of the average price.
  ppt_ctrl #(
    .DIV_STEPS (PRICE_BITS + FRAC_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // Datapath holds the tracked state, the arithmetic and the result register.
  ppt_dp #(
    .PRICE_BITS (PRICE_BITS),
    .QTY_BITS   (QTY_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .status             (status),
    .cfg_load           (cfg_load),
    .cfg_cash           (pwdata),
    .strategy_is_buyer  (strategy_is_buyer),
    .strategy_is_seller (strategy_is_seller),
    .fill_quantity      (fill_quantity),
    .fill_price         (fill_price),
    .net_position       (net_position),
    .entry_price        (entry_price),
    .cash_balance       (cash_balance),
    .pnl_valid          (pnl_valid),
    .realized_pnl       (realized_pnl),
    .position_overflow  (position_overflow)
  );

endmodule

`default_nettype wire

/* hdl/ppt_checker.sv */
// Port-level assertions for the tracker and their bind.
`default_nettype none

module ppt_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic signed [31:0] net_position,
  input wire logic [47:0]        entry_price,
  input wire logic               pnl_valid,
  input wire logic signed [63:0] realized_pnl,
  input wire logic               position_overflow
);

  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result beat present right after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(net_position) &&
      $stable(realized_pnl))
    else $error("stalled result beat changed");

  a_pnl_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !pnl_valid |-> realized_pnl == 64'sd0)
    else $error("realized PnL nonzero without a close");

  a_ovf_at_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid && position_overflow |->
      (net_position == 32'sh7fff_ffff || net_position == 32'sh8000_0000))
    else $error("overflow flagged off the position limit");

  a_flat_no_price: assert property (@(posedge clk) disable iff (rst)
    out_valid && net_position == 32'sd0 |-> entry_price == 48'd0)
    else $error("entry price nonzero while flat");

endmodule

bind position_pnl_tracker ppt_checker u_ppt_checker (
  .clk               (clk),
  .rst               (rst),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .net_position      (net_position),
  .entry_price       (entry_price),
  .pnl_valid         (pnl_valid),
  .realized_pnl      (realized_pnl),
  .position_overflow (position_overflow)
);

`default_nettype wire

/* test/position_pnl_tracker_tb.sv */
`timescale 1ns / 1ps
// Testbench for the position and PnL tracker: directed, random and full-size fill streams.
module position_pnl_tracker_tb;

  localparam int WATCHDOG_LIMIT = 2000;   // cycles with no beat on either side
  localparam int DRAIN_CYCLES   = 100;    // settle time after the last result
  localparam int RANDOM_FILLS   = 650;
  localparam logic [ppt_pkg::PADDR_W-1:0] ADDR_INITIAL_CASH =
    {ppt_pkg::REG_INITIAL_CASH, 2'b00};
  localparam logic [19:0] QTY_MAX   = 20'hF_FFFF;
  localparam logic [31:0] PRICE_MAX = 32'hFFFF_FFFF;
  localparam longint POS_MAX = 64'sd2147483647;
  localparam longint POS_MIN = -64'sd2147483648;
  localparam logic signed [127:0] PNL_MAX = 128'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [127:0] PNL_MIN = -128'sh8000_0000_0000_0000;

  // book state after one fill, as the result beat shows it
  typedef struct {
    logic signed [31:0] pos;
    logic [47:0]        avg;
    logic [63:0]        cash;
    logic               pvalid;
    logic [63:0]        pnl;
    logic               ovf;
  } book_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        strategy_is_buyer = 1'b0;
  logic        strategy_is_seller = 1'b0;
  logic [19:0] fill_quantity = '0;
  logic [31:0] fill_price = '0;

  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] net_position;
  logic [47:0]        entry_price;
  logic signed [63:0] cash_balance;
  logic               pnl_valid;
  logic signed [63:0] realized_pnl;
  logic               position_overflow;

  logic                        psel = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite = 1'b0;
  logic [ppt_pkg::PADDR_W-1:0] paddr = '0;
  logic [31:0]                 pwdata = '0;
  logic [31:0]                 prdata;
  logic                        pready;

  position_pnl_tracker dut (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .strategy_is_buyer  (strategy_is_buyer),
    .strategy_is_seller (strategy_is_seller),
    .fill_quantity      (fill_quantity),
    .fill_price         (fill_price),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .net_position       (net_position),
    .entry_price        (entry_price),
    .cash_balance       (cash_balance),
    .pnl_valid          (pnl_valid),
    .realized_pnl       (realized_pnl),
    .position_overflow  (position_overflow),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  initial forever #5 clk = ~clk;

  // Model of the book: position, average entry price (16 fraction bits), cash.
  logic signed [31:0] pos_m;
  logic [47:0]        avg_m;
  logic [63:0]        cash_m;
  logic [31:0]        init_cash_m;

  book_t fill_outcomes[$];   // expected result beats, oldest first
  book_t head;

  int errors = 0;
  int beats_seen = 0;
  int n_fills = 0;
  int n_closes = 0;
  int n_ovf = 0;
  int n_cfg = 0;
  int idle_run = 0;
  int stall_left = 0;
  bit src_idle = 1'b0;
  bit sink_idle = 1'b0;

  // Apply one fill to the model book and return the beat it should produce.
  function automatic book_t apply_fill(input logic buy, input logic sell,
                                       input logic [19:0] qty, input logic [31:0] price);
    book_t r;
    logic [47:0] px;
    longint pos, np, q, a_s, p_s, diff;
    logic [63:0] qu, mag, nmag, closed, rest;
    logic [127:0] num;
    logic signed [127:0] prod;
    logic adding;
    px = {price, 16'h0000};
    q = 64'(qty);
    qu = 64'(qty);
    r.pvalid = 1'b0;
    r.pnl = '0;
    r.ovf = 1'b0;
    if (buy || sell) begin
      pos = 64'(pos_m);
      adding = buy ? (pos >= 0) : (pos <= 0);
      mag = (pos < 0) ? -pos : pos;
      if (adding) begin
        np = buy ? pos + q : pos - q;
        if (np > POS_MAX) begin
          np = POS_MAX;
          r.ovf = 1'b1;
        end
        if (np < POS_MIN) begin
          np = POS_MIN;
          r.ovf = 1'b1;
        end
        nmag = (np < 0) ? -np : np;
        // only the quantity actually added enters the average
        if (nmag == 0) begin
          avg_m = '0;
        end else begin
          num = mag * avg_m + (nmag - mag) * px;
          num = num / nmag;
          avg_m = num[47:0];
        end
        pos_m = np[31:0];
      end else begin
        closed = (qu < mag) ? qu : mag;
        rest = qu - closed;
        if (closed != 0) begin
          r.pvalid = 1'b1;
          a_s = 64'(avg_m);
          p_s = 64'(px);
          diff = buy ? a_s - p_s : p_s - a_s;
          prod = $signed({64'd0, closed}) * diff;
          if (prod > PNL_MAX) r.pnl = 64'h7FFF_FFFF_FFFF_FFFF;
          else if (prod < PNL_MIN) r.pnl = 64'h8000_0000_0000_0000;
          else r.pnl = prod[63:0];
        end
        mag = mag - closed;
        pos_m = 32'((pos < 0) ? -mag : mag);
        if (mag == 0) avg_m = '0;
        // leftover opens a fresh position at the fill price
        if (rest != 0) begin
          pos_m = 32'(buy ? rest : -rest);
          avg_m = px;
        end
      end
      if (buy) cash_m = cash_m - qty * price;
      else cash_m = cash_m + qty * price;
    end
    r.pos = pos_m;
    r.avg = avg_m;
    r.cash = cash_m;
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    $display("MISMATCH beat %0d %s: got %h, want %h", beats_seen, what, got, want);
    errors++;
  endtask

  // All driving tasks start and end on a falling edge.
  task automatic send_fill(input logic buy, input logic sell,
                           input logic [19:0] qty, input logic [31:0] price);
    book_t r;
    if (src_idle && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    strategy_is_buyer = buy;
    strategy_is_seller = sell;
    fill_quantity = qty;
    fill_price = price;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    r = apply_fill(buy, sell, qty, price);
    fill_outcomes.insert(fill_outcomes.size(), r);
    n_fills++;
    if (r.pvalid) n_closes++;
    if (r.ovf) n_ovf++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic wait_drained();
    while (fill_outcomes.size() != 0) @(negedge clk);
  endtask

  task automatic check_initial_cash();
    logic [31:0] got;
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = ADDR_INITIAL_CASH;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    if (got !== init_cash_m)
      flag_mismatch("initial_cash readback", 64'(got), 64'(init_cash_m));
  endtask

  // Only while the book is idle; the write also reloads cash.
  task automatic write_initial_cash(input logic [31:0] value);
    wait_drained();
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = ADDR_INITIAL_CASH;
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    init_cash_m = value;
    cash_m = 64'(value);
    n_cfg++;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    check_initial_cash();
  endtask

  function automatic logic [19:0] pick_qty();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return QTY_MAX;
      2, 3:    return 20'($urandom_range(1, 15));
      4, 5:    return 20'($urandom);
      default: return 20'($urandom_range(1, 5000));
    endcase
  endfunction

  function automatic logic [31:0] pick_price();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return PRICE_MAX;
      2:       return $urandom_range(1, 255);
      3, 4:    return $urandom;
      default: return $urandom_range(90000, 110000);
    endcase
  endfunction

  // Output side: random stall bursts of random length while enabled.
  always @(negedge clk) begin
    if (stall_left != 0) begin
      out_stall = 1'b1;
      stall_left--;
    end else if (sink_idle && $urandom_range(0, 4) == 0) begin
      out_stall = 1'b1;
      stall_left = $urandom_range(0, 3);
    end else begin
      out_stall = 1'b0;
    end
  end

  // Result checker: each accepted beat against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (fill_outcomes.size() == 0) begin
        flag_mismatch("beat with no fill waiting", 64'(net_position), '0);
      end else begin
        head = fill_outcomes.pop_front();
        if (net_position !== head.pos)
          flag_mismatch("net_position", 64'(net_position), 64'(head.pos));
        if (entry_price !== head.avg)
          flag_mismatch("entry_price", 64'(entry_price), 64'(head.avg));
        if (cash_balance !== head.cash) flag_mismatch("cash_balance", cash_balance, head.cash);
        if (pnl_valid !== head.pvalid)
          flag_mismatch("pnl_valid", 64'(pnl_valid), 64'(head.pvalid));
        if (realized_pnl !== head.pnl) flag_mismatch("realized_pnl", realized_pnl, head.pnl);
        if (position_overflow !== head.ovf)
          flag_mismatch("position_overflow", 64'(position_overflow), 64'(head.ovf));
      end
      beats_seen++;
    end
  end

  // Watchdog: a hung handshake ends the run.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_run = 0;
    end else begin
      idle_run++;
      if (idle_run >= WATCHDOG_LIMIT) begin
        $display("timeout: no beat for %0d cycles, %0d results pending",
                 idle_run, fill_outcomes.size());
        $display("position_pnl_tracker_tb NOT OK");
        $finish;
      end
    end
  end

  task automatic test_reset_values();
    check_initial_cash();
    // neither side: book must show the reset state
    send_fill(1'b0, 1'b0, 20'($urandom), $urandom);
  endtask

  task automatic test_initial_cash();
    write_initial_cash('0);
    send_fill(1'b1, 1'b0, 10, 3);             // cash goes below zero
    write_initial_cash(PRICE_MAX);
    send_fill(1'b0, 1'b1, 10, PRICE_MAX);     // exact close back to flat
    write_initial_cash(ppt_pkg::INITIAL_CASH_RESET);
  endtask

  task automatic test_fill_cases();
    send_fill(1'b0, 1'b0, QTY_MAX, PRICE_MAX);
    send_fill(1'b1, 1'b0, 0, PRICE_MAX);      // zero qty from flat, avg stays zero
    send_fill(1'b0, 1'b1, 0, 0);
    send_fill(1'b1, 1'b1, 1000, 12345);       // both flags count as a buy
    send_fill(1'b0, 1'b1, 1000, 12000);       // exact close, avg clears
    send_fill(1'b1, 1'b0, QTY_MAX, PRICE_MAX);
    send_fill(1'b1, 1'b1, 1000, 12345);       // add, average by division
    send_fill(1'b0, 1'b0, 1, 1);
    send_fill(1'b0, 1'b1, 0, PRICE_MAX);      // zero qty against long: no close
    send_fill(1'b0, 1'b1, 500, PRICE_MAX);    // partial close at a gain
    send_fill(1'b0, 1'b1, QTY_MAX, 0);        // loss beyond 64 bits saturates low
    send_fill(1'b0, 1'b1, QTY_MAX, 1);        // close remainder, flip short
    send_fill(1'b0, 1'b1, 7, 9);
    send_fill(1'b1, 1'b0, 0, 5);              // zero qty against short
    send_fill(1'b1, 1'b0, 3, 2);
    send_fill(1'b1, 1'b1, QTY_MAX, PRICE_MAX);// both flags close the short and flip
    send_fill(1'b1, 1'b0, QTY_MAX, 0);        // drags the average way down
    send_fill(1'b0, 1'b1, QTY_MAX, PRICE_MAX);// gain beyond 64 bits saturates high
    send_fill(1'b0, 1'b1, QTY_MAX, PRICE_MAX);
  endtask

  task automatic test_random_fills();
    longint mag;
    logic buy, sell;
    int i;
    // start from flat so closes and flips around zero are frequent
    mag = 64'(pos_m);
    while (mag != 0) begin
      buy = (mag < 0);
      if (mag < 0) mag = -mag;
      send_fill(buy, !buy, (mag > QTY_MAX) ? QTY_MAX : mag[19:0], pick_price());
      mag = 64'(pos_m);
    end
    for (i = 0; i < RANDOM_FILLS; i++) begin
      case (i)
        0: begin
          src_idle = 1'b1;
          sink_idle = 1'b1;
        end
        250: begin
          src_idle = 1'b0;
          sink_idle = 1'b0;
        end
        350: begin
          wait_drained();                   // sender holds off until the book drains
          write_initial_cash($urandom);
          src_idle = 1'b1;
          sink_idle = 1'b1;
        end
        500: begin
          src_idle = 1'b0;
          sink_idle = 1'b0;
        end
        default: ;
      endcase
      mag = 64'(pos_m);
      if (mag < 0) mag = -mag;
      if (mag != 0 && mag <= QTY_MAX && $urandom_range(0, 15) == 0) begin
        // exact flatten
        buy = (pos_m < 0);
        send_fill(buy, !buy, mag[19:0], pick_price());
      end else begin
        case ($urandom_range(0, 15))
          0:             {buy, sell} = 2'b00;
          1:             {buy, sell} = 2'b11;
          2, 3, 4, 5, 6, 7, 8: {buy, sell} = 2'b10;
          default:       {buy, sell} = 2'b01;
        endcase
        send_fill(buy, sell, pick_qty(), pick_price());
      end
    end
  endtask

  // Full-size fills back to back: long adds, a flip to short and a close.
  task automatic test_large_fills();
    int i;
    src_idle = 1'b0;
    sink_idle = 1'b0;
    for (i = 0; i < 16; i++) send_fill(1'b1, 1'b0, QTY_MAX, $urandom);
    for (i = 0; i < 32; i++) send_fill(1'b0, 1'b1, QTY_MAX, $urandom);
    send_fill(1'b1, 1'b0, QTY_MAX, $urandom);
  endtask

  initial begin
    pos_m = '0;
    avg_m = '0;
    init_cash_m = ppt_pkg::INITIAL_CASH_RESET;
    cash_m = 64'(ppt_pkg::INITIAL_CASH_RESET);
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_values();
    test_initial_cash();
    test_fill_cases();
    test_random_fills();
    test_large_fills();

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("summary: %0d fills, %0d beats checked, %0d with realized PnL, %0d saturating",
             n_fills, beats_seen, n_closes, n_ovf);
    $display("summary: %0d initial_cash writes, stall bursts on both sides, %0d mismatches",
             n_cfg, errors);
    if (errors == 0) begin
      $display("position_pnl_tracker_tb OK");
    end else begin
      $display("position_pnl_tracker_tb NOT OK");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/ppt_pkg.sv
hdl/ppt_ctrl.sv
hdl/ppt_dp.sv
hdl/position_pnl_tracker.sv
hdl/ppt_checker.sv
test/position_pnl_tracker_tb.sv
